### rtl/core/tnqs_pkg.sv
package tnqs_pkg;

  // queue sizing
  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = IDX_W + 1;

  localparam logic [IDX_W-1:0] HEAD_LAST  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FILL_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(QUEUE_DEPTH);

  // input word codes
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_ENQ  = 2'd1,
    MODE_STOP = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  // playback state
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NOTE,
    ST_GAP
  } play_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] freq_hz;
    logic [15:0] duration_ms;
  } in_word_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] tone_freq;
    logic        playing;
    logic        dropped;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic store_write;
    logic load_note;
    logic load_bypass;
    logic load_gap;
    logic count_down;
    logic clear;
    logic out_load;
    logic tone_on;
    logic playing;
    logic dropped;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_zero;
    logic fill_full;
    logic gap_zero;
    logic rem_le1;
  } dp_status_t;

endpackage

### rtl/core/tnqs_ctrl.sv
module tnqs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tnqs_pkg::dp_status_t status,
  output tnqs_pkg::dp_cmd_t    cmd
);

  tnqs_pkg::play_state_t state;
  tnqs_pkg::play_state_t state_next;
  logic                  out_valid_next;
  logic                  accept;

  // one word in flight, taken while the result register is free or draining
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tnqs_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next playback state
  always_comb begin
    state_next = state;
    if (accept) begin
      case (tnqs_pkg::mode_t'(in_mode))
        tnqs_pkg::MODE_TICK: begin
          case (state)
            tnqs_pkg::ST_NOTE: begin
              if (status.rem_le1) begin
                if (!status.fill_zero && !status.gap_zero) begin
                  state_next = tnqs_pkg::ST_GAP;
                end else if (!status.fill_zero) begin
                  state_next = tnqs_pkg::ST_NOTE;
                end else begin
                  state_next = tnqs_pkg::ST_IDLE;
                end
              end
            end
            tnqs_pkg::ST_GAP: begin
              if (status.rem_le1) begin
                state_next = status.fill_zero ? tnqs_pkg::ST_IDLE : tnqs_pkg::ST_NOTE;
              end
            end
            default: state_next = state;
          endcase
        end
        tnqs_pkg::MODE_ENQ: begin
          if (!status.fill_full && state == tnqs_pkg::ST_IDLE) begin
            state_next = tnqs_pkg::ST_NOTE;
          end
        end
        tnqs_pkg::MODE_STOP: state_next = tnqs_pkg::ST_IDLE;
        default:             state_next = state;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.tone_on  = (state_next == tnqs_pkg::ST_NOTE);
    cmd.playing  = (state_next != tnqs_pkg::ST_IDLE);
    if (accept) begin
      cmd.out_load = 1'b1;
      case (tnqs_pkg::mode_t'(in_mode))
        tnqs_pkg::MODE_TICK: begin
          case (state)
            tnqs_pkg::ST_NOTE: begin
              if (status.rem_le1) begin
                if (!status.fill_zero && !status.gap_zero) begin
                  cmd.load_gap = 1'b1;
                end else if (!status.fill_zero) begin
                  cmd.load_note = 1'b1;
                end
              end else begin
                cmd.count_down = 1'b1;
              end
            end
            tnqs_pkg::ST_GAP: begin
              if (status.rem_le1) begin
                cmd.load_note = ~status.fill_zero;
              end else begin
                cmd.count_down = 1'b1;
              end
            end
            default: cmd.count_down = 1'b0;
          endcase
        end
        tnqs_pkg::MODE_ENQ: begin
          if (status.fill_full) begin
            cmd.dropped = 1'b1;
          end else if (state == tnqs_pkg::ST_IDLE) begin
            cmd.load_bypass = 1'b1;
          end else begin
            cmd.store_write = 1'b1;
          end
        end
        tnqs_pkg::MODE_STOP: cmd.clear = 1'b1;
        default:             cmd.clear = 1'b0;
      endcase
    end
  end

endmodule

### rtl/core/tnqs_datapath.sv
module tnqs_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  input  tnqs_pkg::in_word_t   in_data,
  output tnqs_pkg::out_word_t  out_data,
  input  tnqs_pkg::dp_cmd_t    cmd,
  output tnqs_pkg::dp_status_t status
);

  logic [15:0]                note_freq_store [tnqs_pkg::QUEUE_DEPTH];
  logic [15:0]                note_len_store  [tnqs_pkg::QUEUE_DEPTH];
  logic [tnqs_pkg::IDX_W-1:0] queue_head;
  logic [tnqs_pkg::CNT_W-1:0] queue_fill;
  logic [15:0]                remaining_ms;
  logic [15:0]                current_freq;
  logic [15:0]                current_freq_next;
  logic [15:0]                gap_ms;

  logic [tnqs_pkg::IDX_W-1:0] head_inc;
  logic [tnqs_pkg::SUM_W-1:0] tail_sum;
  logic [tnqs_pkg::IDX_W-1:0] tail;

  // ring pointers
  assign head_inc = (queue_head == tnqs_pkg::HEAD_LAST) ? '0 : queue_head + 1'b1;
  assign tail_sum = {1'b0, queue_head} + tnqs_pkg::SUM_W'(queue_fill);
  assign tail     = (tail_sum >= tnqs_pkg::DEPTH_SUM)
                  ? tnqs_pkg::IDX_W'(tail_sum - tnqs_pkg::DEPTH_SUM)
                  : tnqs_pkg::IDX_W'(tail_sum);

  assign status.fill_zero = (queue_fill == '0);
  assign status.fill_full = (queue_fill == tnqs_pkg::FILL_FULL);
  assign status.gap_zero  = (gap_ms == 16'd0);
  assign status.rem_le1   = (remaining_ms[15:1] == 15'd0);

  // gap register
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ms <= 16'd0;
    end else if (cfg_we) begin
      gap_ms <= cfg_data;
    end
  end

  // note store, written at the tail
  always_ff @(posedge clk) begin
    if (cmd.store_write) begin
      note_freq_store[tail] <= in_data.freq_hz;
      note_len_store[tail]  <= in_data.duration_ms;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      queue_head <= '0;
      queue_fill <= '0;
    end else if (cmd.load_note) begin
      queue_head <= head_inc;
      queue_fill <= queue_fill - 1'b1;
    end else if (cmd.load_bypass) begin
      queue_head <= head_inc;
    end else if (cmd.store_write) begin
      queue_fill <= queue_fill + 1'b1;
    end
  end

  // sounding note frequency
  always_comb begin
    if (cmd.load_note) begin
      current_freq_next = note_freq_store[queue_head];
    end else if (cmd.load_bypass) begin
      current_freq_next = in_data.freq_hz;
    end else begin
      current_freq_next = current_freq;
    end
  end

  // countdown and note register
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_ms <= 16'd0;
      current_freq <= 16'd0;
    end else begin
      current_freq <= current_freq_next;
      if (cmd.load_note) begin
        remaining_ms <= note_len_store[queue_head];
      end else if (cmd.load_bypass) begin
        remaining_ms <= in_data.duration_ms;
      end else if (cmd.load_gap) begin
        remaining_ms <= gap_ms;
      end else if (cmd.count_down) begin
        remaining_ms <= remaining_ms - 16'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.tone_on   <= cmd.tone_on;
      out_data.tone_freq <= cmd.tone_on ? current_freq_next : 16'd0;
      out_data.playing   <= cmd.playing;
      out_data.dropped   <= cmd.dropped;
    end
  end

endmodule

### rtl/core/tone_note_queue_sequencer.sv
// channel  direction  word                      handshake
// in       input      in_data (mode/freq/dur)   in_valid, in_stall
// out      output     out_data (tone/status)    out_valid, out_stall
// cfg      input      cfg_data (gap_ms)         cfg_we
//
// each word is handled at the accepting edge, where the state update and the result
// register load happen; the result shows in the following cycle
// one word per cycle while out_stall is low; in_stall follows a held result
// rst is synchronous: queue empty, idle, gap_ms zero, no result pending
module tone_note_queue_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tnqs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tnqs_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);

  tnqs_pkg::dp_cmd_t    cmd;
  tnqs_pkg::dp_status_t status;

  // playback control
  tnqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // queue, countdown and result register
  tnqs_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .status   (status)
  );

endmodule
